### rtl/core/ywgc_pkg.sv
package ywgc_pkg;

  localparam int NUM_CFG      = 8;
  localparam int CFG_IDX_W    = 4;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int IN_W         = 272;
  localparam int OUT_W        = 304;

  localparam logic signed [25:0] DEG360    = 26'sd23592960;
  localparam logic signed [25:0] DEG180    = 26'sd11796480;
  localparam logic signed [25:0] DEG90     = 26'sd5898240;
  localparam logic signed [25:0] WRAP_STEP = 26'sd21233664;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [20:0] G_Q16     = 21'sd642908;

  typedef enum logic [2:0] {
    CFG_PITCH_ANG  = 3'd0,
    CFG_ROLL_ANG   = 3'd1,
    CFG_PITCH_RATE = 3'd2,
    CFG_YAW_RATE   = 3'd3,
    CFG_ROLL_RATE  = 3'd4,
    CFG_ACCEL_X    = 3'd5,
    CFG_ACCEL_Y    = 3'd6,
    CFG_ACCEL_Z    = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_PREP, OP_ROT, OP_MUL_C, OP_MUL_S, OP_SUM,
    OP_SC_X, OP_SC_Y, OP_SC_Z, OP_FINISH
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic signed [25:0] z;
    logic               neg_cos;
  } fold_t;

  function automatic logic signed [25:0] atan_deg(input logic [STEP_W-1:0] i);
    logic signed [25:0] v;
    unique case (i)
      4'd0:  v = 26'sd2949120;
      4'd1:  v = 26'sd1740967;
      4'd2:  v = 26'sd919879;
      4'd3:  v = 26'sd466945;
      4'd4:  v = 26'sd234379;
      4'd5:  v = 26'sd117306;
      4'd6:  v = 26'sd58666;
      4'd7:  v = 26'sd29335;
      4'd8:  v = 26'sd14668;
      4'd9:  v = 26'sd7334;
      4'd10: v = 26'sd3667;
      4'd11: v = 26'sd1833;
      4'd12: v = 26'sd917;
      4'd13: v = 26'sd458;
      4'd14: v = 26'sd229;
      default: v = 26'sd115;
    endcase
    return v;
  endfunction

  function automatic fold_t fold_angle(input logic signed [24:0] ang);
    fold_t f;
    logic signed [25:0] a;
    a = 26'(ang);
    if (a >= DEG180) a = a - DEG360;
    if (a < -DEG180) a = a + DEG360;
    f.neg_cos = 1'b0;
    f.z = a;
    if (a > DEG90) begin
      f.z = DEG180 - a;
      f.neg_cos = 1'b1;
    end else if (a < -DEG90) begin
      f.z = -DEG180 - a;
      f.neg_cos = 1'b1;
    end
    return f;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [31:0] r;
    if (v > 41'sd2147483647) r = 32'sh7fffffff;
    else if (v < -41'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

### rtl/core/ywgc_ctrl.sv
module ywgc_ctrl
  import ywgc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_axis_tvalid,
  output logic    s_axis_tready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_ROT, S_MUL_C, S_MUL_S, S_SUM, S_SC_X, S_SC_Y, S_SC_Z, S_DONE
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;

  assign s_axis_tready = (state == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE:  if (s_axis_tvalid) state <= S_PREP;
        S_PREP: begin
          step  <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          step <= step + 1'b1;
          if (step == STEP_W'(CORDIC_STEPS - 1)) state <= S_MUL_C;
        end
        S_MUL_C: state <= S_MUL_S;
        S_MUL_S: state <= S_SUM;
        S_SUM:   state <= S_SC_X;
        S_SC_X:  state <= S_SC_Y;
        S_SC_Y:  state <= S_SC_Z;
        S_SC_Z:  state <= S_DONE;
        S_DONE:  if (!st.out_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.step = step;
    unique case (state)
      S_IDLE:  cmd.op = s_axis_tvalid ? OP_LOAD : OP_NONE;
      S_PREP:  cmd.op = OP_PREP;
      S_ROT:   cmd.op = OP_ROT;
      S_MUL_C: cmd.op = OP_MUL_C;
      S_MUL_S: cmd.op = OP_MUL_S;
      S_SUM:   cmd.op = OP_SUM;
      S_SC_X:  cmd.op = OP_SC_X;
      S_SC_Y:  cmd.op = OP_SC_Y;
      S_SC_Z:  cmd.op = OP_SC_Z;
      S_DONE:  cmd.op = st.out_busy ? OP_NONE : OP_FINISH;
      default: cmd.op = OP_NONE;
    endcase
  end

  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !st.out_busy) |=> s_axis_tready)
    else $error("controller did not return to idle after finishing");

endmodule

### rtl/core/ywgc_dp.sv
module ywgc_dp
  import ywgc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              st,
  input  logic [IN_W-1:0]      s_axis_tdata,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata
);

  logic signed [31:0] cfg [NUM_CFG];

  logic signed [24:0] p, r, yw, prev_yaw;
  logic signed [31:0] gx, gy, gz, ax, ay, az;
  logic signed [15:0] wrap_cnt;

  logic signed [33:0] px, py, rx, ry;
  logic signed [25:0] pz, rz;
  logic               pneg, rneg;
  logic signed [33:0] cp, cr, prod_c, prod_s;
  logic signed [47:0] sx, sy, sz, sc_sel;
  logic signed [33:0] q16;
  logic signed [54:0] ms, msx, msy, msz;
  logic signed [63:0] mul_w;

  logic signed [24:0] in_p, in_r, in_y;
  logic signed [25:0] ydiff;
  fold_t              fp, fr;

  logic signed [31:0] o_pa, o_ra, o_pr, o_yr, o_rr, o_lx, o_ly, o_lz;
  logic signed [40:0] o_ya;

  assign in_p  = s_axis_tdata[24:0];
  assign in_r  = s_axis_tdata[49:25];
  assign in_y  = s_axis_tdata[74:50];
  assign ydiff = 26'(in_y) - 26'(prev_yaw);
  assign fp    = fold_angle(p);
  assign fr    = fold_angle(r);
  assign cp    = pneg ? -px : px;
  assign cr    = rneg ? -rx : rx;
  assign st.out_busy = m_axis_tvalid && !m_axis_tready;

  always_comb begin
    mul_w = $signed(cr[31:0]) * $signed(cp[31:0]);
    if (cmd.op == OP_MUL_S) mul_w = $signed(ry[31:0]) * $signed(cp[31:0]);
  end

  always_comb begin
    priority case (cmd.op)
      OP_SC_X: sc_sel = sx;
      OP_SC_Y: sc_sel = sy;
      default: sc_sel = sz;
    endcase
    q16 = 34'((sc_sel + 48'sd8192) >>> 14);
    ms  = 55'(q16) * 55'(G_Q16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CFG; i++) cfg[i] <= '0;
    end else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_CFG)) begin
      cfg[cfg_index[2:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_yaw <= '0;
      wrap_cnt <= '0;
    end else if (cmd.op == OP_LOAD) begin
      prev_yaw <= in_y;
      if (ydiff >= WRAP_STEP) begin
        if (wrap_cnt != -16'sd32768) wrap_cnt <= wrap_cnt - 16'sd1;
      end else if (ydiff <= -WRAP_STEP) begin
        if (wrap_cnt != 16'sd32767) wrap_cnt <= wrap_cnt + 16'sd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        p  <= in_p;
        r  <= in_r;
        yw <= in_y;
        gx <= s_axis_tdata[106:75];
        gy <= s_axis_tdata[138:107];
        gz <= s_axis_tdata[170:139];
        ax <= s_axis_tdata[202:171];
        ay <= s_axis_tdata[234:203];
        az <= s_axis_tdata[266:235];
      end
      OP_PREP: begin
        px <= CORDIC_GAIN;
        py <= '0;
        pz <= fp.z;
        pneg <= fp.neg_cos;
        rx <= CORDIC_GAIN;
        ry <= '0;
        rz <= fr.z;
        rneg <= fr.neg_cos;
      end
      OP_ROT: begin
        if (pz >= 0) begin
          px <= px - (py >>> cmd.step);
          py <= py + (px >>> cmd.step);
          pz <= pz - atan_deg(cmd.step);
        end else begin
          px <= px + (py >>> cmd.step);
          py <= py - (px >>> cmd.step);
          pz <= pz + atan_deg(cmd.step);
        end
        if (rz >= 0) begin
          rx <= rx - (ry >>> cmd.step);
          ry <= ry + (rx >>> cmd.step);
          rz <= rz - atan_deg(cmd.step);
        end else begin
          rx <= rx + (ry >>> cmd.step);
          ry <= ry - (rx >>> cmd.step);
          rz <= rz + atan_deg(cmd.step);
        end
      end
      OP_MUL_C: prod_c <= mul_w[63:30];
      OP_MUL_S: prod_s <= mul_w[63:30];
      OP_SUM: begin
        sx <= (48'(ax) <<< 14) + 48'(py);
        sy <= (48'(az) <<< 14) - 48'(prod_c);
        sz <= 48'(prod_s) - (48'(ay) <<< 14);
      end
      OP_SC_X: msx <= ms;
      OP_SC_Y: msy <= ms;
      OP_SC_Z: msz <= ms;
      OP_FINISH: begin
        o_pa <= sat32(-41'(p) - 41'(cfg[CFG_PITCH_ANG]));
        o_ra <= sat32(41'(r) - 41'(cfg[CFG_ROLL_ANG]));
        o_ya <= -(41'(yw) + 41'(wrap_cnt) * 41'(DEG360));
        o_pr <= sat32(-41'(gy) - 41'(cfg[CFG_PITCH_RATE]));
        o_yr <= sat32(-41'(gz) - 41'(cfg[CFG_YAW_RATE]));
        o_rr <= sat32(41'(gx) - 41'(cfg[CFG_ROLL_RATE]));
        o_lx <= sat32(41'((msx + 55'sd32768) >>> 16) - 41'(cfg[CFG_ACCEL_X]));
        o_ly <= sat32(41'((msy + 55'sd32768) >>> 16) - 41'(cfg[CFG_ACCEL_Y]));
        o_lz <= sat32(41'((msz + 55'sd32768) >>> 16) - 41'(cfg[CFG_ACCEL_Z]));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.op == OP_FINISH) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {7'b0, o_lz, o_ly, o_lx, o_rr, o_yr, o_pr, o_ya, o_ra, o_pa};

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_FINISH) |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("result overwritten before it was taken");

  a_wrap_hold: assert property (@(posedge clk) disable iff (rst)
    (cmd.op != OP_LOAD && !rst) |=> $stable(wrap_cnt))
    else $error("wrap count moved without an item");

endmodule

### rtl/core/imu_yaw_unwrap_gravity_comp.sv
// Conditions IMU records: unwraps yaw (a jump of 324 deg or more steps a
// saturating 16-bit wrap count), remaps and negates axes, removes gravity from
// the accelerations using CORDIC sin/cos of pitch and roll, scales to m/s^2 and
// subtracts the offset registers. One item in gives one item out. The result
// is presented after load, preparation, the 16-step CORDIC that works on
// pitch and roll side by side, two products, a sum, three scalings and the
// finish; the input is ready again as the result is presented, not before. A
// result still waiting in the output register holds off the next item.
module imu_yaw_unwrap_gravity_comp
  import ywgc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // pitch_deg, roll_deg, yaw_deg, gyro_x, gyro_y, gyro_z, accel_x_g, accel_y_g, accel_z_g
  input  logic [IN_W-1:0]      s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // pitch_out, roll_out, yaw_unwrapped, pitch_rate, yaw_rate, roll_rate,
  // lin_accel_x, lin_accel_y, lin_accel_z
  output logic [OUT_W-1:0]     m_axis_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = !rst;

  ywgc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .st            (st),
    .cmd           (cmd)
  );

  ywgc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .s_axis_tdata  (s_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
